@@ src/leif_pkg.sv @@
// Package: shared types, constants and helpers for the line edit input FIFO.
package leif_pkg;

  localparam int RING_DEPTH = 512;
  localparam int MAX_READ   = 64;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = 7;
  localparam int PEND_W     = 9;

  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;

  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(RING_DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_V   = (PTR_W + 1)'(RING_DEPTH);
  localparam logic [CNT_W-1:0] MAX_READ_V = CNT_W'(MAX_READ);

  typedef enum logic [1:0] {
    KIND_ECHO  = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef struct packed {
    logic             cmd;
    logic [7:0]       key_char;
    logic             key_pressed;
    logic [CNT_W-1:0] read_count;
  } in_t;

  typedef struct packed {
    kind_t             result_kind;
    logic [7:0]        out_byte;
    logic              last_of_run;
    logic [PEND_W-1:0] pending_chars;
  } out_t;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(logic [PTR_W-1:0] p);
    return (p == '0) ? LAST_PTR : p - PTR_W'(1);
  endfunction

  function automatic logic [PEND_W-1:0] pending(logic [PTR_W-1:0] w, logic [PTR_W-1:0] r);
    logic [PTR_W:0] d;
    logic [31:0]    d32;
    d   = (w >= r) ? ({1'b0, w} - {1'b0, r}) : (DEPTH_V - {1'b0, r} + {1'b0, w});
    d32 = 32'(d);
    return d32[PEND_W-1:0];
  endfunction

endpackage

@@ src/leif_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module leif_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/line_edit_input_fifo.sv @@
// Top level: keyboard line-input ring buffer with backspace echo.
// Key echo: S_ECHO registers the result once the output is free; a backspace
// gives 3 results on consecutive free output cycles.
// Read: per character, a RAM read (S_RD_REQ) then an output load (S_RD_DATA).
// Input is taken only in S_IDLE, after the previous run of results has been loaded.
// Reset: rst_n synchronous, clears pointers, state and output valid; RAM is not cleared.
module line_edit_input_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  leif_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output leif_pkg::out_t out_data
);
  import leif_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ECHO,
    S_BS,
    S_EMPTY,
    S_RD_REQ,
    S_RD_DATA
  } state_t;

  state_t           state_r, state_nxt;
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;

  logic             in_fire, out_free, out_load;
  logic             ram_we, ram_re;
  logic [7:0]       ram_rdata;
  logic [CNT_W-1:0] cnt_sat;
  logic [PTR_W-1:0] rp_adv;
  logic             rd_last;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cnt_sat   = (in_data.read_count > MAX_READ_V) ? MAX_READ_V : in_data.read_count;
  assign rp_adv    = ptr_inc(rp_r);
  assign rd_last   = (cnt_r == CNT_W'(1)) || (rp_adv == wp_r) || (ram_rdata == CH_NEWLINE);

  leif_ram #(
    .WIDTH(8),
    .DEPTH(RING_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp_r),
    .wdata(in_data.key_char),
    .re   (ram_re),
    .raddr(rp_r),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    wp_nxt       = wp_r;
    rp_nxt       = rp_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    byte_nxt     = byte_r;
    out_data_nxt = out_data_r;
    out_load     = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (!in_data.cmd) begin
            if (in_data.key_pressed && in_data.key_char != 8'd0) begin
              if (in_data.key_char == CH_BACKSPACE) begin
                if (wp_r != rp_r) begin
                  wp_nxt    = ptr_dec(wp_r);
                  idx_nxt   = 2'd0;
                  state_nxt = S_BS;
                end
              end else if (ptr_inc(wp_r) != rp_r) begin
                ram_we    = 1'b1;
                wp_nxt    = ptr_inc(wp_r);
                byte_nxt  = in_data.key_char;
                state_nxt = S_ECHO;
              end
            end
          end else if (cnt_sat == '0 || wp_r == rp_r) begin
            state_nxt = S_EMPTY;
          end else begin
            cnt_nxt   = cnt_sat;
            state_nxt = S_RD_REQ;
          end
        end
      end
      S_ECHO: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_data_nxt = '{KIND_ECHO, byte_r, 1'b1, pending(wp_r, rp_r)};
          state_nxt    = S_IDLE;
        end
      end
      S_BS: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_data_nxt = '{KIND_ECHO, (idx_r == 2'd1) ? CH_SPACE : CH_BACKSPACE,
                           idx_r == 2'd2, pending(wp_r, rp_r)};
          idx_nxt      = idx_r + 2'd1;
          if (idx_r == 2'd2) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_data_nxt = '{KIND_EMPTY, 8'd0, 1'b1, pending(wp_r, rp_r)};
          state_nxt    = S_IDLE;
        end
      end
      S_RD_REQ: begin
        ram_re    = 1'b1;
        state_nxt = S_RD_DATA;
      end
      S_RD_DATA: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_data_nxt = '{KIND_DATA, ram_rdata, rd_last, pending(wp_r, rp_adv)};
          rp_nxt       = rp_adv;
          cnt_nxt      = cnt_r - CNT_W'(1);
          state_nxt    = rd_last ? S_IDLE : S_RD_REQ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    byte_r     <= byte_nxt;
    out_data_r <= out_data_nxt;
  end

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, wp_r} < DEPTH_V) && ({1'b0, rp_r} < DEPTH_V))
    else $error("ring pointer out of range");

  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.cmd && (wp_r == rp_r) |=> state_r == S_EMPTY)
    else $error("read of empty ring not flagged");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && out_data_nxt.last_of_run |=> state_r == S_IDLE)
    else $error("last result did not return to idle");

  a_data_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && state_r == S_RD_DATA |=> out_data_r.result_kind == KIND_DATA)
    else $error("read result has wrong kind");

  a_bs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_data.cmd && in_data.key_pressed && in_data.key_char == CH_BACKSPACE
      && wp_r != rp_r
    |=> pending(wp_r, rp_r) == $past(pending(wp_r, rp_r)) - PEND_W'(1))
    else $error("backspace did not remove one character");

endmodule

@@ tb/line_edit_input_fifo_test.sv @@
`timescale 1ns / 100ps
// Testbench for line_edit_input_fifo: directed and random key/read traffic checked against a line-buffer predictor.
module line_edit_input_fifo_test;
  import leif_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_WAIT = 18;
  localparam int LIVE_TARGET = 200;
  localparam logic CMD_KEY = 1'b0;
  localparam logic CMD_READ = 1'b1;

  class line_echo_scoreboard;
    logic [7:0] ring [RING_DEPTH];
    int unsigned wr_ptr;
    int unsigned rd_ptr;
    out_t predicted_outs[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned items_seen;
    int unsigned dropped_chars;
    int unsigned erased_chars;
    int unsigned empty_reads;

    function new();
      wr_ptr = 0;
      rd_ptr = 0;
      mismatches = 0;
      results_seen = 0;
      items_seen = 0;
      dropped_chars = 0;
      erased_chars = 0;
      empty_reads = 0;
    endfunction

    function int unsigned stored();
      return (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
    endfunction

    function void push_result(kind_t kind, logic [7:0] data, logic last);
      out_t r;
      r.result_kind = kind;
      r.out_byte = data;
      r.last_of_run = last;
      r.pending_chars = PEND_W'(stored());
      predicted_outs.push_back(r);
    endfunction

    function void note_input(in_t t);
      int unsigned lim;
      int unsigned n;
      logic [7:0] c;
      out_t tail;
      items_seen++;
      if (t.cmd == CMD_KEY) begin
        if (!t.key_pressed || t.key_char == 8'd0) return;
        if (t.key_char == CH_BACKSPACE) begin
          if (wr_ptr == rd_ptr) return;
          wr_ptr = (wr_ptr == 0) ? RING_DEPTH - 1 : wr_ptr - 1;
          erased_chars++;
          push_result(KIND_ECHO, CH_BACKSPACE, 1'b0);
          push_result(KIND_ECHO, CH_SPACE, 1'b0);
          push_result(KIND_ECHO, CH_BACKSPACE, 1'b1);
          return;
        end
        if ((wr_ptr + 1) % RING_DEPTH == rd_ptr) begin
          dropped_chars++;
          return;
        end
        ring[wr_ptr] = t.key_char;
        wr_ptr = (wr_ptr + 1) % RING_DEPTH;
        push_result(KIND_ECHO, t.key_char, 1'b1);
        return;
      end
      lim = (t.read_count > MAX_READ) ? MAX_READ : t.read_count;
      n = 0;
      while (n < lim && rd_ptr != wr_ptr) begin
        c = ring[rd_ptr];
        rd_ptr = (rd_ptr + 1) % RING_DEPTH;
        n++;
        push_result(KIND_DATA, c, 1'b0);
        if (c == CH_NEWLINE) break;
      end
      if (n == 0) begin
        empty_reads++;
        push_result(KIND_EMPTY, 8'd0, 1'b1);
      end else begin
        tail = predicted_outs.pop_back();
        tail.last_of_run = 1'b1;
        predicted_outs.push_back(tail);
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      bit bad;
      results_seen++;
      if (predicted_outs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d byte %02h last %0b pending %0d",
                   got.result_kind, got.out_byte, got.last_of_run, got.pending_chars);
        return;
      end
      want = predicted_outs.pop_front();
      bad = (got.result_kind !== want.result_kind) || (got.out_byte !== want.out_byte) ||
            (got.last_of_run !== want.last_of_run) ||
            (got.pending_chars !== want.pending_chars);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch %0d: expected kind %0d byte %02h last %0b pending %0d, got kind %0d byte %02h last %0b pending %0d",
                   mismatches, want.result_kind, want.out_byte, want.last_of_run,
                   want.pending_chars, got.result_kind, got.out_byte, got.last_of_run,
                   got.pending_chars);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  line_echo_scoreboard sb;
  bit src_calm;
  bit sink_calm;
  int unsigned live_items;
  int unsigned cycles = 0;

  line_edit_input_fifo u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int draw_wait(bit calm);
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic [7:0] rand_glyph();
    logic [7:0] c;
    do c = 8'($urandom); while (c == 8'd0 || c == CH_BACKSPACE || c == CH_NEWLINE);
    return c;
  endfunction

  function automatic in_t key_item(logic [7:0] ch, logic pressed);
    in_t t;
    t.cmd = CMD_KEY;
    t.key_char = ch;
    t.key_pressed = pressed;
    t.read_count = CNT_W'($urandom);
    return t;
  endfunction

  function automatic in_t read_item(int unsigned cnt);
    in_t t;
    t.cmd = CMD_READ;
    t.key_char = 8'($urandom);
    t.key_pressed = 1'($urandom);
    t.read_count = CNT_W'(cnt);
    return t;
  endfunction

  task automatic send_item(input in_t item);
    int gap;
    gap = draw_wait(src_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_input(item);
    if (item.cmd == CMD_READ || (item.key_pressed && item.key_char != 8'd0)) live_items++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.predicted_outs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // result sink with random stalls
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_wait(sink_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_result(out_data);
    end
  end

  initial begin
    int pick;
    int len;
    int cnt;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    src_calm = 1'b0;
    sink_calm = 1'b0;
    live_items = 0;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty ring, ignored keys, extremes, backspace, count limits
    send_item(read_item(5));
    send_item(read_item(0));
    send_item(key_item(CH_BACKSPACE, 1'b1));
    send_item(key_item("a", 1'b0));
    send_item(key_item(8'd0, 1'b1));
    send_item(key_item(8'hFF, 1'b1));
    send_item(key_item(8'h01, 1'b1));
    send_item(key_item("h", 1'b1));
    send_item(key_item(CH_NEWLINE, 1'b1));
    send_item(key_item("x", 1'b1));
    send_item(key_item(CH_BACKSPACE, 1'b1));
    send_item(key_item(CH_BACKSPACE, 1'b0));
    send_item(read_item(0));
    send_item(read_item(127));
    send_item(key_item("a", 1'b1));
    send_item(key_item("b", 1'b1));
    send_item(key_item("c", 1'b1));
    send_item(read_item(2));
    send_item(read_item(MAX_READ));
    send_item(read_item(1));
    send_item(key_item("z", 1'b1));
    send_item(key_item(CH_BACKSPACE, 1'b1));
    send_item(read_item(MAX_READ + 1));

    // fill the ring past full, then drain it; pointers end up wrapped
    repeat (RING_DEPTH + 2) send_item(key_item(rand_glyph(), 1'b1));
    send_item(key_item(CH_BACKSPACE, 1'b1));
    send_item(key_item(rand_glyph(), 1'b1));
    send_item(key_item(rand_glyph(), 1'b1));
    while (sb.stored() != 0)
      send_item(read_item($urandom_range(0, 1) ? MAX_READ : 100));
    send_item(read_item(MAX_READ));
    send_item(key_item("q", 1'b1));
    send_item(key_item(CH_BACKSPACE, 1'b1));
    wait_drained();

    // random: mostly typed lines followed by reads, plus noise
    live_items = 0;
    while (live_items < LIVE_TARGET) begin
      src_calm = ($urandom_range(0, 4) == 0);
      sink_calm = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        len = $urandom_range(0, 12);
        repeat (len) begin
          case ($urandom_range(0, 9))
            0: send_item(key_item(CH_BACKSPACE, 1'b1));
            1: send_item(key_item(8'($urandom), 1'b0));
            default: send_item(key_item(rand_glyph(), 1'b1));
          endcase
        end
        if ($urandom_range(0, 4) != 0) send_item(key_item(CH_NEWLINE, 1'b1));
        case ($urandom_range(0, 19))
          0: cnt = 0;
          1, 2: cnt = $urandom_range(MAX_READ + 1, 127);
          3, 4, 5: cnt = $urandom_range(1, MAX_READ - 1);
          default: cnt = MAX_READ;
        endcase
        send_item(read_item(cnt));
      end else if (pick < 75) begin
        send_item(read_item($urandom_range(0, 127)));
      end else if (pick < 90) begin
        send_item(key_item(8'($urandom), 1'($urandom)));
      end else begin
        repeat ($urandom_range(1, 4)) send_item(key_item(CH_BACKSPACE, 1'b1));
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end

    src_calm = 1'b0;
    sink_calm = 1'b0;
    wait_drained();
    repeat (40) @(posedge clk);

    $display("Ran %0d input transactions and checked %0d results (%0d reads found nothing).",
             sb.items_seen, sb.results_seen, sb.empty_reads);
    $display("Ring filled to capacity with %0d chars dropped, %0d erased; %0d mismatches, %0d left over.",
             sb.dropped_chars, sb.erased_chars, sb.mismatches, sb.predicted_outs.size());
    if (sb.mismatches == 0 && sb.predicted_outs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/leif_pkg.sv
src/leif_ram.sv
src/line_edit_input_fifo.sv
tb/line_edit_input_fifo_test.sv
